@@ hdl/srpp_pkg.sv @@
`default_nettype none
package srpp_pkg;

  // Size of the receive buffer; longer packets are clamped to it.
  localparam int BUFFER_BYTES = 128;
  // Length of one accelerometer, gyroscope or magnetometer record.
  localparam int RECORD_BYTES = 10;

  localparam logic [7:0]  BUF_LEN      = 8'(BUFFER_BYTES);
  localparam logic [3:0]  REC_LEN      = 4'(RECORD_BYTES);
  localparam logic [7:0]  TIMESTAMP_ID = 8'hFB;
  localparam logic [3:0]  TS_LEFT      = 4'd4;
  localparam logic [14:0] LEN_MIN      = 15'd2;
  localparam logic [7:0]  HEADER_BYTES = 8'd4;

  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_MAG   = 2'd2;

  localparam logic [7:0] CFG_ACCEL_ID = 8'd0;
  localparam logic [7:0] CFG_GYRO_ID  = 8'd1;
  localparam logic [7:0] CFG_MAG_ID   = 8'd2;
  localparam logic [7:0] CFG_CHANNEL  = 8'd3;

  typedef struct packed {
    logic [7:0] accel_id;
    logic [7:0] gyro_id;
    logic [7:0] mag_id;
    logic [7:0] channel;
  } srpp_cfg_t;

  typedef struct packed {
    logic        report_valid;
    logic [1:0]  sensor_kind;
    logic [15:0] value_x;
    logic [15:0] value_y;
    logic [15:0] value_z;
    logic        packet_done;
    logic        any_updated;
  } srpp_result_t;

endpackage
`default_nettype wire

@@ hdl/srpp_core.sv @@
`default_nettype none
module srpp_core
  import srpp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         packet_start_i,
  input  wire srpp_cfg_t    cfg_i,
  output logic              res_valid_o,
  output srpp_result_t      res_o
);

  logic [7:0]  pos_q, pos_d, len_q, len_d, low_q, low_d;
  logic        chm_q, chm_d, stop_q, stop_d, skip_q, skip_d, upd_q, upd_d;
  logic [3:0]  left_q, left_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] ax_q [3];
  logic [15:0] ax_d [3];

  logic [7:0]  pos_c, len_c;
  logic        stop_c, skip_c, upd_c;
  logic [3:0]  left_c, kind_k;
  logic [1:0]  kind_c, id_kind;
  logic        id_known, rec_valid, done;
  logic [14:0] len15, len_clamp;

  always_comb begin
    // A start flag reinitializes the packet state before this byte is used.
    pos_c  = packet_start_i ? 8'd0 : pos_q;
    len_c  = packet_start_i ? BUF_LEN : len_q;
    stop_c = packet_start_i ? 1'b0 : stop_q;
    skip_c = packet_start_i ? 1'b0 : skip_q;
    upd_c  = packet_start_i ? 1'b0 : upd_q;
    left_c = packet_start_i ? 4'd0 : left_q;
    kind_c = packet_start_i ? 2'd0 : kind_q;

    pos_d  = pos_c;
    len_d  = len_c;
    low_d  = low_q;
    chm_d  = packet_start_i ? 1'b0 : chm_q;
    stop_d = stop_c;
    skip_d = skip_c;
    upd_d  = upd_c;
    left_d = left_c;
    kind_d = kind_c;
    ax_d   = ax_q;

    rec_valid = 1'b0;
    done      = 1'b0;

    len15 = {data_byte_i[6:0], low_q};
    if (len15 > {7'd0, BUF_LEN}) begin
      len_clamp = {7'd0, BUF_LEN};
    end else if (len15 < LEN_MIN) begin
      len_clamp = LEN_MIN;
    end else begin
      len_clamp = len15;
    end

    // Register priority: accelerometer, then gyroscope, then magnetometer.
    id_known = 1'b1;
    if (data_byte_i == cfg_i.accel_id) begin
      id_kind = KIND_ACCEL;
    end else if (data_byte_i == cfg_i.gyro_id) begin
      id_kind = KIND_GYRO;
    end else if (data_byte_i == cfg_i.mag_id) begin
      id_kind = KIND_MAG;
    end else begin
      id_kind  = KIND_ACCEL;
      id_known = 1'b0;
    end

    kind_k = REC_LEN - left_c;

    if (pos_c < len_c) begin
      case (pos_c)
        8'd0: begin
          low_d = data_byte_i;
        end
        8'd1: begin
          len_d = len_clamp[7:0];
        end
        8'd2: begin
          chm_d = (data_byte_i == cfg_i.channel);
          if (data_byte_i != cfg_i.channel) begin
            stop_d = 1'b1;
          end
        end
        default: begin
          if (pos_c >= HEADER_BYTES && !stop_c) begin
            if (left_c == 4'd0) begin
              if (data_byte_i == TIMESTAMP_ID) begin
                skip_d = 1'b1;
                left_d = TS_LEFT;
              end else if (!id_known ||
                           ({1'b0, pos_c} + {5'd0, REC_LEN}) > {1'b0, len_c}) begin
                stop_d = 1'b1;
              end else begin
                skip_d = 1'b0;
                kind_d = id_kind;
                left_d = REC_LEN - 4'd1;
              end
            end else begin
              if (!skip_c) begin
                case (kind_k)
                  4'd4: ax_d[0][7:0]  = data_byte_i;
                  4'd5: ax_d[0][15:8] = data_byte_i;
                  4'd6: ax_d[1][7:0]  = data_byte_i;
                  4'd7: ax_d[1][15:8] = data_byte_i;
                  4'd8: ax_d[2][7:0]  = data_byte_i;
                  4'd9: ax_d[2][15:8] = data_byte_i;
                  default: ;
                endcase
              end
              left_d = left_c - 4'd1;
              if (left_d == 4'd0 && !skip_c) begin
                upd_d     = 1'b1;
                rec_valid = 1'b1;
              end
            end
          end
        end
      endcase
      pos_d = pos_c + 8'd1;
      done  = ({1'b0, pos_c} + 9'd1) == {1'b0, len_d};
      if (done) begin
        stop_d = 1'b1;
      end
    end
  end

  always_comb begin
    res_valid_o        = accept_i && (rec_valid || done);
    res_o.report_valid = rec_valid;
    res_o.sensor_kind  = rec_valid ? kind_d : 2'd0;
    res_o.value_x      = rec_valid ? ax_d[0] : 16'd0;
    res_o.value_y      = rec_valid ? ax_d[1] : 16'd0;
    res_o.value_z      = rec_valid ? ax_d[2] : 16'd0;
    res_o.packet_done  = done;
    res_o.any_updated  = done && upd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 8'd0;
      len_q  <= 8'd0;
      low_q  <= 8'd0;
      chm_q  <= 1'b0;
      stop_q <= 1'b1;
      skip_q <= 1'b0;
      upd_q  <= 1'b0;
      left_q <= 4'd0;
      kind_q <= 2'd0;
      ax_q   <= '{16'd0, 16'd0, 16'd0};
    end else if (accept_i) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      low_q  <= low_d;
      chm_q  <= chm_d;
      stop_q <= stop_d;
      skip_q <= skip_d;
      upd_q  <= upd_d;
      left_q <= left_d;
      kind_q <= kind_d;
      ax_q   <= ax_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/srpp_out_buf.sv @@
`default_nettype none
module srpp_out_buf
  import srpp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire srpp_result_t push_data_i,
  output logic              can_push_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output srpp_result_t      out_data_o
);

  logic         out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  srpp_result_t out_q, out_d, skid_q, skid_d;
  logic         out_free;

  // The skid stage holds a result that arrives while the output stalls.
  assign can_push_o  = !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = push_i;
        out_d     = push_data_i;
      end
    end else if (push_i) begin
      skid_vld_d = 1'b1;
      skid_d     = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule
`default_nettype wire

@@ hdl/sensor_report_packet_parser_top.sv @@
`default_nettype none
// Sensor report packet parser. Takes one packet byte per item, with a start
// flag on the first byte, and walks the report records that follow the
// four-byte header. One item is accepted every cycle unless input is held
// off. A result (a completed accelerometer, gyroscope or magnetometer record,
// or the packet end) is registered in the output stage. The byte decode sits
// between the packet state registers and a two-deep output stage, so input is
// held off only when that stage is full under output back-pressure.
// Configuration writes set the report ids and the channel; the user must
// make them only while the block is idle; the block does not enforce it.
module sensor_report_packet_parser_top
  import srpp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        packet_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             report_valid_o,
  output logic [1:0]       sensor_kind_o,
  output logic signed [15:0] value_x_o,
  output logic signed [15:0] value_y_o,
  output logic signed [15:0] value_z_o,
  output logic             packet_done_o,
  output logic             any_updated_o
);

  srpp_cfg_t    cfg_q, cfg_d;
  srpp_result_t res, out_res;
  logic         accept, res_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ACCEL_ID: cfg_d.accel_id = cfg_data_i;
        CFG_GYRO_ID:  cfg_d.gyro_id  = cfg_data_i;
        CFG_MAG_ID:   cfg_d.mag_id   = cfg_data_i;
        CFG_CHANNEL:  cfg_d.channel  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_id <= 8'd1;
      cfg_q.gyro_id  <= 8'd2;
      cfg_q.mag_id   <= 8'd3;
      cfg_q.channel  <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  srpp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .cfg_i          (cfg_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  srpp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .can_push_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign report_valid_o = out_res.report_valid;
  assign sensor_kind_o  = out_res.sensor_kind;
  assign value_x_o      = out_res.value_x;
  assign value_y_o      = out_res.value_y;
  assign value_z_o      = out_res.value_z;
  assign packet_done_o  = out_res.packet_done;
  assign any_updated_o  = out_res.any_updated;

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
module tb
  import srpp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 290;
  localparam int NUM_PHASES  = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic packet_start_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic report_valid_o;
  logic [1:0] sensor_kind_o;
  logic signed [15:0] value_x_o;
  logic signed [15:0] value_y_o;
  logic signed [15:0] value_z_o;
  logic packet_done_o;
  logic any_updated_o;

  sensor_report_packet_parser_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .report_valid_o (report_valid_o),
    .sensor_kind_o  (sensor_kind_o),
    .value_x_o      (value_x_o),
    .value_y_o      (value_y_o),
    .value_z_o      (value_z_o),
    .packet_done_o  (packet_done_o),
    .any_updated_o  (any_updated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rx_item_t     byte_q[$];
  srpp_result_t report_q[$];
  srpp_result_t want_r;
  int mismatches = 0;
  int pushed = 0;
  int stall_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  bit in_busy = 1'b0;
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  // Parser state as the testbench tracks it.
  srpp_cfg_t   cfg_model = '{8'd1, 8'd2, 8'd3, 8'd3};
  logic [7:0]  rx_pos = '0;
  logic [7:0]  rx_len = '0;
  logic [7:0]  len_lo = '0;
  logic        chan_ok = 1'b0;
  logic        parse_off = 1'b1;
  logic [3:0]  rec_left = '0;
  logic [1:0]  rec_kind = '0;
  logic        rec_skip = 1'b0;
  logic [15:0] axis_acc [3] = '{16'd0, 16'd0, 16'd0};
  logic        got_record = 1'b0;

  function automatic void parse_byte(logic [7:0] b, logic start);
    int unsigned p, len, k, idx;
    logic fire, done, found;
    logic [1:0] kind_sel;
    srpp_result_t r;
    fire = 1'b0;
    found = 1'b0;
    kind_sel = KIND_ACCEL;
    if (start) begin
      rx_pos = '0;
      rx_len = BUF_LEN;
      chan_ok = 1'b0;
      parse_off = 1'b0;
      rec_left = '0;
      rec_kind = KIND_ACCEL;
      rec_skip = 1'b0;
      got_record = 1'b0;
    end
    if (rx_pos >= rx_len) return;
    p = 32'(rx_pos);
    if (p == 0) begin
      len_lo = b;
    end else if (p == 1) begin
      len = 32'({b, len_lo} & 16'h7FFF);
      if (len > BUFFER_BYTES) len = BUFFER_BYTES;
      if (len < 2) len = 2;
      rx_len = 8'(len);
    end else if (p == 2) begin
      chan_ok = (b == cfg_model.channel);
      if (!chan_ok) parse_off = 1'b1;
    end else if (p >= HEADER_BYTES && !parse_off) begin
      if (rec_left == 0) begin
        // Timestamp always wins; among sensors, the lower kind wins on equal ids.
        if (b == TIMESTAMP_ID) begin
          rec_skip = 1'b1;
          rec_left = TS_LEFT;
        end else begin
          if (b == cfg_model.accel_id) begin
            found = 1'b1;
            kind_sel = KIND_ACCEL;
          end else if (b == cfg_model.gyro_id) begin
            found = 1'b1;
            kind_sel = KIND_GYRO;
          end else if (b == cfg_model.mag_id) begin
            found = 1'b1;
            kind_sel = KIND_MAG;
          end
          if (!found || p + RECORD_BYTES > 32'(rx_len)) begin
            parse_off = 1'b1;
          end else begin
            rec_skip = 1'b0;
            rec_kind = kind_sel;
            rec_left = REC_LEN - 4'd1;
          end
        end
      end else begin
        k = RECORD_BYTES - 32'(rec_left);
        if (!rec_skip && k >= 4 && k <= 9) begin
          idx = (k - 4) >> 1;
          if ((k & 1) == 0) axis_acc[idx][7:0] = b;
          else axis_acc[idx][15:8] = b;
        end
        rec_left = rec_left - 4'd1;
        if (rec_left == 0 && !rec_skip) begin
          got_record = 1'b1;
          fire = 1'b1;
        end
      end
    end
    rx_pos = 8'(p + 1);
    done = (p + 1 == 32'(rx_len));
    if (done) parse_off = 1'b1;
    if (!fire && !done) return;
    r = '0;
    r.report_valid = fire;
    if (fire) begin
      r.sensor_kind = rec_kind;
      r.value_x = axis_acc[0];
      r.value_y = axis_acc[1];
      r.value_z = axis_acc[2];
    end
    r.packet_done = done;
    r.any_updated = done && got_record;
    report_q.push_back(r);
  endfunction

  task automatic log_mismatch(string msg);
    if (mismatches < 50) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) log_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Output check first: a result at this edge belongs to an item accepted earlier.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (report_q.size() == 0) begin
          log_mismatch("result arrived with nothing pending");
        end else begin
          want_r = report_q.pop_front();
          check_field("report_valid", 16'(report_valid_o), 16'(want_r.report_valid));
          check_field("sensor_kind", 16'(sensor_kind_o), 16'(want_r.sensor_kind));
          check_field("value_x", value_x_o, want_r.value_x);
          check_field("value_y", value_y_o, want_r.value_y);
          check_field("value_z", value_z_o, want_r.value_z);
          check_field("packet_done", 16'(packet_done_o), 16'(want_r.packet_done));
          check_field("any_updated", 16'(any_updated_o), 16'(want_r.any_updated));
        end
      end
      if (in_valid_i && in_ready_o) begin
        parse_byte(data_byte_i, packet_start_i);
        void'(byte_q.pop_front());
        in_busy = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL sensor_report_packet_parser_top");
        $finish;
      end
    end
  end

  // Sender: holds an item until it is taken, idles in random bursts between items.
  always @(negedge clk_i) begin
    if (rst_ni && !in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_valid_i <= 1'b1;
        data_byte_i <= byte_q[0].data;
        packet_start_i <= byte_q[0].start;
        in_busy = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void push_byte(logic [7:0] b, logic start);
    byte_q.push_back('{b, start});
    pushed++;
  endfunction

  function automatic logic [7:0] axis_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed packets; the rest are cut short, carry stray ids,
  // use the wrong channel, or have lengths that end inside the header.
  task automatic gen_packet();
    int mode, eff, limit, pos, i;
    logic [14:0] len15;
    logic [7:0] chan;
    mode = $urandom_range(0, 99);
    if (mode >= 90) len15 = 15'($urandom_range(0, 4));
    else if ($urandom_range(0, 19) == 0) len15 = 15'($urandom_range(129, 32767));
    else len15 = 15'($urandom_range(5, 64));
    eff = 32'(len15);
    if (eff > BUFFER_BYTES) eff = BUFFER_BYTES;
    else if (eff < 2) eff = 2;
    chan = cfg_model.channel;
    if (mode >= 80 && mode < 90) chan = chan ^ 8'($urandom_range(1, 255));
    limit = eff;
    if (mode >= 60 && mode < 70 && eff > 5) limit = $urandom_range(4, eff - 1);
    push_byte(len15[7:0], 1'b1);
    push_byte({1'($urandom), len15[14:8]}, 1'b0);
    push_byte(chan, 1'b0);
    push_byte(8'($urandom), 1'b0);
    pos = 4;
    while (pos < limit) begin
      if (mode >= 70 && mode < 80 && $urandom_range(0, 3) == 0) begin
        push_byte(8'($urandom), 1'b0);
        pos++;
      end else if ($urandom_range(0, 4) == 0) begin
        push_byte(TIMESTAMP_ID, 1'b0);
        for (i = 0; i < 4; i++) push_byte(8'($urandom), 1'b0);
        pos += 5;
      end else if (pos + RECORD_BYTES <= eff) begin
        case ($urandom_range(0, 2))
          0: push_byte(cfg_model.accel_id, 1'b0);
          1: push_byte(cfg_model.gyro_id, 1'b0);
          default: push_byte(cfg_model.mag_id, 1'b0);
        endcase
        for (i = 0; i < 3; i++) push_byte(8'($urandom), 1'b0);
        for (i = 0; i < 6; i++) push_byte(axis_byte(), 1'b0);
        pos += RECORD_BYTES;
      end else begin
        push_byte(8'($urandom), 1'b0);
        pos++;
      end
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_busy || report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_cfg(srpp_cfg_t c);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_ACCEL_ID;
    cfg_data_i <= c.accel_id;
    @(negedge clk_i);
    cfg_index_i <= CFG_GYRO_ID;
    cfg_data_i <= c.gyro_id;
    @(negedge clk_i);
    cfg_index_i <= CFG_MAG_ID;
    cfg_data_i <= c.mag_id;
    @(negedge clk_i);
    cfg_index_i <= CFG_CHANNEL;
    cfg_data_i <= c.channel;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_model = c;
  endtask

  initial begin
    srpp_cfg_t c;
    int target;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: c = '{8'd1, 8'd2, 8'd3, 8'd3};
        2: c = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        3: c = '{TIMESTAMP_ID, 8'h10, 8'h10, 8'h00};
        default: c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      apply_cfg(c);
      if (ph == 0) begin
        // A stray byte before any start is ignored.
        push_byte(8'h55, 1'b0);
        // Zero length counts as two and ends on the second byte.
        push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b0);
        // Length three with bit 15 set ends inside the header.
        push_byte(8'h03, 1'b1); push_byte(8'h80, 1'b0); push_byte(8'd3, 1'b0);
        // One accelerometer record with extreme axis values.
        push_byte(8'h0E, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'd3, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'd1, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h7F, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        // A timestamp that runs past the end of a six-byte packet.
        push_byte(8'h06, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'd3, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(TIMESTAMP_ID, 1'b0); push_byte(8'h11, 1'b0);
      end
      if (ph == 1) hold_req = 1'b1;
      if (ph == NUM_PHASES - 1) no_idle = 1'b1;
      target = pushed + PHASE_ITEMS;
      while (pushed < target) gen_packet();
    end
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS sensor_report_packet_parser_top");
    end else begin
      $display("FAIL sensor_report_packet_parser_top");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/srpp_pkg.sv
hdl/srpp_core.sv
hdl/srpp_out_buf.sv
hdl/sensor_report_packet_parser_top.sv
bench/tb.sv
